[src/dcs_pkg.sv]
package dcs_pkg;

    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned IN_USER_W  = 4;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned OUT_USER_W = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    localparam logic [7:0] LEN_DRIVE   = 8'd4;
    localparam logic [7:0] LEN_LATERAL = 8'd6;
    localparam logic [7:0] LEN_STREAM  = 8'd6;
    localparam logic [7:0] LEN_AUX     = 8'd3;
    localparam logic [7:0] LEN_ESTOP   = 8'd1;

    typedef enum logic [3:0] {
        OP_TICK       = 4'd0,
        OP_HELLO      = 4'd1,
        OP_DESCRIBE   = 4'd2,
        OP_SET_STREAM = 4'd3,
        OP_DRIVE      = 4'd4,
        OP_DRIVE_RAW  = 4'd5,
        OP_STOP       = 4'd6,
        OP_ESTOP      = 4'd7,
        OP_SET_AUX    = 4'd8,
        OP_PING       = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT   = 2'd0,
        CFG_HOLONOMIC = 2'd1,
        CFG_AUX       = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ACK_OK            = 3'd0,
        ACK_BAD_LENGTH    = 3'd1,
        ACK_ESTOP         = 3'd2,
        ACK_NOT_SUPPORTED = 3'd3,
        ACK_UNKNOWN       = 3'd4
    } ack_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_DRIVING = 2'd1,
        MODE_ESTOP   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_VELOCITY = 2'd1,
        ACT_RAW      = 2'd2,
        ACT_STOP     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REPLY_NONE  = 2'd0,
        REPLY_ACK   = 2'd1,
        REPLY_HELLO = 2'd2
    } reply_t;

endpackage

[src/drive_command_supervisor_core.sv]
// Drive command supervisor. Each input item is either a watchdog tick (opcode 0
// in s_tuser) or a decoded command message; every item yields exactly one
// result item carrying the reply (none, ack or hello ack), the drive output
// (none, velocity, raw wheels or stop) and the supervisor status after the
// item. The block is a two-register pipeline: an input register and a result
// register with the compare-and-update logic between them, so it takes one item
// per clock unless the output is back-pressured. A result is presented on
// m_tvalid once its item moves from the input register to the result register
// and is held until taken. The input stalls only while both registers hold an
// item and m_tready is low. The only wide path is the 32-bit elapsed-time
// subtract and compare for the watchdog. Configuration writes on cfg_* are
// always ready and must be issued only while no item is in flight.
module drive_command_supervisor_core
    import dcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms[31:0], msg_seq[39:32], payload_len[47:40], first_byte[55:48],
    // word_a[71:56], word_b[87:72], word_c[103:88]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode[3:0]
    input  logic [IN_USER_W-1:0]  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // reply_seq[7:0], acked_type[11:8], ack_code[14:12], drive_action[16:15],
    // drive_linear[32:17], drive_angular[48:33], drive_lateral[64:49],
    // mode_now[66:65], estop_latched[67], timeout_fired[68], zero[71:69]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // reply_kind[1:0]
    output logic [OUT_USER_W-1:0] m_tuser
);

    // Configuration registers
    logic [15:0] timeout_reg;
    logic        holonomic_reg;
    logic        aux_reg;

    // Supervisor state
    mode_t       mode_reg, mode_next;
    logic        estop_reg, estop_next;
    logic        motors_reg, motors_next;
    logic [31:0] last_cmd_reg, last_cmd_next;

    // Input stage
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic [IN_USER_W-1:0] in_user_reg;

    // Result stage
    logic        out_valid_reg;
    reply_t      kind_reg, kind_next;
    logic [7:0]  rseq_reg, rseq_next;
    logic [3:0]  atype_reg, atype_next;
    ack_t        code_reg, code_next;
    action_t     act_reg, act_next;
    logic [15:0] lin_reg, lin_next;
    logic [15:0] ang_reg, ang_next;
    logic [15:0] lat_reg, lat_next;
    logic        fired_reg, fired_next;

    logic        advance;

    // Unpacked view of the staged item
    opcode_t     op;
    logic [31:0] now_ms;
    logic [7:0]  msg_seq;
    logic [7:0]  payload_len;
    logic [7:0]  first_byte;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] side;
    logic [31:0] elapsed;

    assign op          = opcode_t'(in_user_reg);
    assign now_ms      = in_data_reg[31:0];
    assign msg_seq     = in_data_reg[39:32];
    assign payload_len = in_data_reg[47:40];
    assign first_byte  = in_data_reg[55:48];
    assign word_a      = in_data_reg[71:56];
    assign word_b      = in_data_reg[87:72];
    assign word_c      = in_data_reg[103:88];

    // Lateral only counts when the message is long enough to carry it
    assign side    = (payload_len >= LEN_LATERAL) ? word_c : 16'd0;
    assign elapsed = now_ms - last_cmd_reg;

    // Advance the staged item whenever the result register is free or draining
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        kind_next     = REPLY_ACK;
        rseq_next     = msg_seq;
        atype_next    = in_user_reg;
        code_next     = ACK_OK;
        act_next      = ACT_NONE;
        lin_next      = 16'd0;
        ang_next      = 16'd0;
        lat_next      = 16'd0;
        fired_next    = 1'b0;
        mode_next     = mode_reg;
        estop_next    = estop_reg;
        motors_next   = motors_reg;
        last_cmd_next = now_ms;

        unique case (op)
            OP_TICK:
            begin
                kind_next     = REPLY_NONE;
                rseq_next     = 8'd0;
                atype_next    = 4'd0;
                last_cmd_next = last_cmd_reg;
                if (timeout_reg != 16'd0 && motors_reg &&
                    elapsed >= {16'd0, timeout_reg})
                begin
                    motors_next = 1'b0;
                    if (mode_reg == MODE_DRIVING)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    act_next   = ACT_STOP;
                    fired_next = 1'b1;
                end
            end
            OP_HELLO:
            begin
                kind_next = REPLY_HELLO;
            end
            OP_DESCRIBE, OP_PING:
            begin
            end
            OP_SET_STREAM:
            begin
                if (payload_len < LEN_STREAM)
                begin
                    code_next = ACK_BAD_LENGTH;
                end
            end
            OP_DRIVE:
            begin
                priority if (payload_len < LEN_DRIVE)
                begin
                    code_next = ACK_BAD_LENGTH;
                end
                else if (estop_reg)
                begin
                    code_next = ACK_ESTOP;
                end
                else if (side != 16'd0 && !holonomic_reg)
                begin
                    code_next = ACK_NOT_SUPPORTED;
                end
                else
                begin
                    act_next    = ACT_VELOCITY;
                    lin_next    = word_a;
                    ang_next    = word_b;
                    lat_next    = side;
                    motors_next = (word_a != 16'd0) || (word_b != 16'd0) ||
                                  (side != 16'd0);
                    mode_next   = motors_next ? MODE_DRIVING : MODE_IDLE;
                end
            end
            OP_DRIVE_RAW:
            begin
                priority if (payload_len < LEN_DRIVE)
                begin
                    code_next = ACK_BAD_LENGTH;
                end
                else if (estop_reg)
                begin
                    code_next = ACK_ESTOP;
                end
                else
                begin
                    act_next    = ACT_RAW;
                    lin_next    = word_a;
                    ang_next    = word_b;
                    motors_next = (word_a != 16'd0) || (word_b != 16'd0);
                    mode_next   = motors_next ? MODE_DRIVING : MODE_IDLE;
                end
            end
            OP_STOP:
            begin
                motors_next = 1'b0;
                if (mode_reg == MODE_DRIVING)
                begin
                    mode_next = MODE_IDLE;
                end
                act_next = ACT_STOP;
            end
            OP_ESTOP:
            begin
                if (payload_len >= LEN_ESTOP && first_byte != 8'd0)
                begin
                    // Engage: latch, kill motors, enter emergency-stop mode
                    estop_next  = 1'b1;
                    motors_next = 1'b0;
                    mode_next   = MODE_ESTOP;
                    act_next    = ACT_STOP;
                end
                else
                begin
                    // Release: clear the latch, leave emergency-stop mode
                    estop_next = 1'b0;
                    if (mode_reg == MODE_ESTOP)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            OP_SET_AUX:
            begin
                priority if (payload_len < LEN_AUX)
                begin
                    code_next = ACK_BAD_LENGTH;
                end
                else if (!aux_reg)
                begin
                    code_next = ACK_NOT_SUPPORTED;
                end
                else
                begin
                    code_next = ACK_OK;
                end
            end
            default:
            begin
                code_next = ACK_UNKNOWN;
            end
        endcase
    end

    // Configuration writes; out-of-range index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            holonomic_reg <= 1'b0;
            aux_reg       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                CFG_HOLONOMIC: holonomic_reg <= cfg_data[0];
                CFG_AUX:       aux_reg       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    // State update and result register: commit only when the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            estop_reg     <= 1'b0;
            motors_reg    <= 1'b0;
            last_cmd_reg  <= 32'd0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                mode_reg     <= mode_next;
                estop_reg    <= estop_next;
                motors_reg   <= motors_next;
                last_cmd_reg <= last_cmd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            kind_reg  <= kind_next;
            rseq_reg  <= rseq_next;
            atype_reg <= atype_next;
            code_reg  <= code_next;
            act_reg   <= act_next;
            lin_reg   <= lin_next;
            ang_reg   <= ang_next;
            lat_reg   <= lat_next;
            fired_reg <= fired_next;
        end
    end

    // Status fields live in the state registers, which change only when the
    // result register loads, so they stay aligned with the held result.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {3'd0, fired_reg, estop_reg, mode_reg, lat_reg, ang_reg,
                       lin_reg, act_reg, code_reg, atype_reg, rseq_reg};

    // The latch only exists together with emergency-stop mode
    a_estop_mode: assert property (@(posedge clk) disable iff (!rst_n)
        estop_reg |-> mode_reg == MODE_ESTOP)
        else $error("estop latched outside emergency-stop mode");

    // Motors run exactly when the node is driving
    a_motors_mode: assert property (@(posedge clk) disable iff (!rst_n)
        motors_reg == (mode_reg == MODE_DRIVING))
        else $error("motors flag and driving mode disagree");

    // A watchdog stop carries no reply and always issues stop
    a_fired_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fired_reg) |-> (kind_reg == REPLY_NONE && act_reg == ACT_STOP))
        else $error("watchdog result without stop action");

    // Input stalls only when both stages are full and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // Time of last command moves only when a message is committed
    a_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && in_valid_reg) |=> $stable(last_cmd_reg))
        else $error("last command time changed without a message");

endmodule
